@@ rtl/lprt_pkg.sv @@
package lprt_pkg;

	localparam int DEF_TABLE_DEPTH     = 16;
	localparam int DEF_INTERFACE_COUNT = 8;
	localparam int ADDR_W              = 32;
	localparam int IFC_W               = 3;
	localparam int PLEN_W              = 6;

	typedef enum logic [1:0] {
		ACT_LOOKUP = 2'd0,
		ACT_ADD    = 2'd1,
		ACT_DELETE = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]        action;
		logic [ADDR_W-1:0] address;
		logic [ADDR_W-1:0] gateway;
		logic [ADDR_W-1:0] route_mask;
		logic [IFC_W-1:0]  interface_id;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [IFC_W-1:0]  found_interface;
		logic [ADDR_W-1:0] found_gateway;
		logic [ADDR_W-1:0] next_hop;
		logic [PLEN_W-1:0] prefix_length;
	} rsp_t;

	// route held in one cell; plen is cached at insertion
	typedef struct packed {
		logic [ADDR_W-1:0] network;
		logic [ADDR_W-1:0] gateway;
		logic [ADDR_W-1:0] mask;
		logic [IFC_W-1:0]  ifc;
		logic [PLEN_W-1:0] plen;
	} ent_data_t;

	// request traveling down the chain, with the running best match
	typedef struct packed {
		logic [1:0]        action;
		logic [ADDR_W-1:0] address;
		logic [ADDR_W-1:0] gateway;
		logic [ADDR_W-1:0] mask;
		logic              hit;
		logic              found;
		logic [PLEN_W-1:0] plen;
		logic [ADDR_W-1:0] best_gw;
		logic [IFC_W-1:0]  best_ifc;
	} tok_t;

	// leading ones = 31 - (position of the highest zero), or 32 with no zero
	function automatic logic [PLEN_W-1:0] leading_ones(input logic [ADDR_W-1:0] m);
		logic [PLEN_W-1:0] n;
		n = PLEN_W'(ADDR_W);
		for (int i = 0; i < ADDR_W; i++) begin
			if (!m[i]) begin
				n = PLEN_W'(ADDR_W - 1 - i);
			end
		end
		return n;
	endfunction

endpackage

@@ rtl/lprt_cell.sv @@
module lprt_cell import lprt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      shift,
	input  logic      prev_valid,
	input  ent_data_t prev_data,
	input  logic      next_valid,
	input  ent_data_t next_data,
	input  logic      tok_in_valid,
	input  tok_t      tok_in,
	output logic      ent_valid,
	output ent_data_t ent_data,
	output logic      tok_out_valid,
	output tok_t      tok_out
);

	logic      valid_q;
	ent_data_t data_q;
	logic      tok_valid_q;
	tok_t      tok_q;
	tok_t      tok_nxt;
	logic      is_lookup;
	logic      is_delete;
	logic      lookup_hit;
	logic      delete_hit;
	logic      pull;

	assign is_lookup = tok_in_valid && (tok_in.action == ACT_LOOKUP);
	assign is_delete = tok_in_valid && (tok_in.action == ACT_DELETE);

	assign lookup_hit = is_lookup && valid_q &&
		((tok_in.address & data_q.mask) == (data_q.network & data_q.mask));

	assign delete_hit = is_delete && valid_q && (data_q.network == tok_in.address) &&
		(data_q.gateway == tok_in.gateway) && (data_q.mask == tok_in.mask);

	// once the newest match is found, it and every older cell close the gap
	assign pull = is_delete && (tok_in.found || delete_hit);

	always_comb begin
		tok_nxt = tok_in;
		if (lookup_hit && (!tok_in.hit || (data_q.plen > tok_in.plen))) begin
			tok_nxt.hit      = 1'b1;
			tok_nxt.plen     = data_q.plen;
			tok_nxt.best_gw  = data_q.gateway;
			tok_nxt.best_ifc = data_q.ifc;
		end
		if (delete_hit) begin
			tok_nxt.found = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= 1'b0;
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= tok_in_valid;
			if (shift) begin
				valid_q <= prev_valid;
			end else if (pull) begin
				valid_q <= next_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_nxt;
		if (shift) begin
			data_q <= prev_data;
		end else if (pull) begin
			data_q <= next_data;
		end
	end

	assign ent_valid     = valid_q;
	assign ent_data      = data_q;
	assign tok_out_valid = tok_valid_q;
	assign tok_out       = tok_q;

endmodule

@@ rtl/longest_prefix_route_table.sv @@
// IPv4 route table with longest-prefix lookup, built as a chain of cells.
// Request channel: req_valid/req_ready carry one req beat (action, address,
// gateway, route_mask, interface_id). Response channel: rsp_valid/rsp_ready
// carry one rsp beat per request, in request order.
// Cell 0 holds the newest route. An accepted add with a valid interface
// on a table that is not full shifts the whole chain by one cell; add and
// unused actions answer without a walk, through the response buffer.
// Lookup and delete send the request down the chain one cell per cycle,
// carrying the best match so far (lookup) or a found flag (delete, where
// the matching cell and each cell past it pull in the older neighbor).
// These answer once the request leaves the last cell; adds are taken one
// per cycle while the receiver takes responses. One request is in flight
// at a time; req_ready is low during a walk. A two-entry response buffer
// lets a new request be taken while a response waits; with both entries
// full, req_ready stays low until the receiver takes a beat. Reset empties
// the table and the response buffer, and req_ready is high once it ends.
module longest_prefix_route_table import lprt_pkg::*; #(
	parameter int TABLE_DEPTH     = DEF_TABLE_DEPTH,
	parameter int INTERFACE_COUNT = DEF_INTERFACE_COUNT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic [TABLE_DEPTH-1:0] ent_v;
	ent_data_t              ent_d [TABLE_DEPTH];
	logic [TABLE_DEPTH:0]   tok_v;
	tok_t                   tok_d [TABLE_DEPTH+1];

	logic      accept;
	logic      launch;
	logic      immediate;
	logic      add_ok;
	logic      ifc_bad;
	logic      full;
	ent_data_t new_ent;
	logic      busy_q;
	logic      fin_valid;
	rsp_t      fin_rsp;
	tok_t      last_tok;
	logic      rsp_valid_q;
	rsp_t      rsp_q;
	logic      hold_valid_q;
	rsp_t      hold_q;
	logic      out_free;

	assign req_ready = !busy_q && !hold_valid_q;
	assign accept    = req_valid && req_ready;
	assign ifc_bad   = {6'd0, req.interface_id} >= 9'(INTERFACE_COUNT);
	assign full      = ent_v[TABLE_DEPTH-1];
	assign add_ok    = (req.action == ACT_ADD) && !ifc_bad && !full;

	always_comb begin
		launch    = 1'b0;
		immediate = 1'b0;
		unique case (req.action)
			ACT_LOOKUP, ACT_DELETE: launch = accept;
			default: immediate = accept;
		endcase
	end

	always_comb begin
		new_ent.network = req.address;
		new_ent.gateway = req.gateway;
		new_ent.mask    = req.route_mask;
		new_ent.ifc     = req.interface_id;
		new_ent.plen    = leading_ones(req.route_mask);
	end

	always_comb begin
		tok_d[0].action   = req.action;
		tok_d[0].address  = req.address;
		tok_d[0].gateway  = req.gateway;
		tok_d[0].mask     = req.route_mask;
		tok_d[0].hit      = 1'b0;
		tok_d[0].found    = 1'b0;
		tok_d[0].plen     = '0;
		tok_d[0].best_gw  = '0;
		tok_d[0].best_ifc = '0;
	end
	assign tok_v[0] = launch;

	for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_cell
		logic      pv;
		ent_data_t pd;
		logic      nv;
		ent_data_t nd;

		if (j == 0) begin : g_head
			assign pv = 1'b1;
			assign pd = new_ent;
		end else begin : g_body
			assign pv = ent_v[j-1];
			assign pd = ent_d[j-1];
		end

		if (j == TABLE_DEPTH - 1) begin : g_tail
			assign nv = 1'b0;
			assign nd = ent_d[j];
		end else begin : g_inner
			assign nv = ent_v[j+1];
			assign nd = ent_d[j+1];
		end

		lprt_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.shift        (accept && add_ok),
			.prev_valid   (pv),
			.prev_data    (pd),
			.next_valid   (nv),
			.next_data    (nd),
			.tok_in_valid (tok_v[j]),
			.tok_in       (tok_d[j]),
			.ent_valid    (ent_v[j]),
			.ent_data     (ent_d[j]),
			.tok_out_valid(tok_v[j+1]),
			.tok_out      (tok_d[j+1])
		);
	end

	assign last_tok  = tok_d[TABLE_DEPTH];
	assign fin_valid = tok_v[TABLE_DEPTH] || immediate;

	always_comb begin
		fin_rsp        = '0;
		fin_rsp.status = ST_MISS;
		if (tok_v[TABLE_DEPTH]) begin
			if (last_tok.action == ACT_LOOKUP) begin
				if (last_tok.hit) begin
					fin_rsp.status          = ST_OK;
					fin_rsp.found_interface = last_tok.best_ifc;
					fin_rsp.found_gateway   = last_tok.best_gw;
					fin_rsp.next_hop        = (last_tok.best_gw != '0) ?
						last_tok.best_gw : last_tok.address;
					fin_rsp.prefix_length   = last_tok.plen;
				end
			end else if (last_tok.found) begin
				fin_rsp.status = ST_OK;
			end
		end else if (req.action == ACT_ADD) begin
			if (ifc_bad) begin
				fin_rsp.status = ST_MISS;
			end else if (full) begin
				fin_rsp.status = ST_FULL;
			end else begin
				fin_rsp.status = ST_OK;
			end
		end
	end

	assign out_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			rsp_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else begin
			if (launch) begin
				busy_q <= 1'b1;
			end else if (tok_v[TABLE_DEPTH]) begin
				busy_q <= 1'b0;
			end
			if (out_free) begin
				if (hold_valid_q) begin
					rsp_valid_q  <= 1'b1;
					hold_valid_q <= 1'b0;
				end else begin
					rsp_valid_q <= fin_valid;
				end
			end else if (fin_valid) begin
				hold_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (hold_valid_q) begin
				rsp_q <= hold_q;
			end else if (fin_valid) begin
				rsp_q <= fin_rsp;
			end
		end else if (fin_valid) begin
			hold_q <= fin_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// at most one request walks the chain
	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_v[TABLE_DEPTH:1]))
		else $error("more than one request in the chain");

	assert property (@(posedge clk) disable iff (!arst_n)
		req_ready |-> (tok_v[TABLE_DEPTH:1] == '0))
		else $error("ready while a request is in the chain");

	assert property (@(posedge clk) disable iff (!arst_n)
		hold_valid_q |-> rsp_valid_q)
		else $error("hold buffer full with output register empty");

	assert property (@(posedge clk) disable iff (!arst_n)
		launch |=> busy_q)
		else $error("walk launched without busy");

	// valid routes form a run starting at cell 0
	assert property (@(posedge clk) disable iff (!arst_n)
		(ent_v & ~((ent_v << 1) | TABLE_DEPTH'(1))) == '0)
		else $error("gap in the route table");

endmodule
